/* rtl/core/dndc_pkg.sv */
// Shared types, codes and calendar tables for the day-number / date converter.
// No dependencies; used by day_number_date_converter_unit.
`timescale 1ns / 1ps

package dndc_pkg;

  // Field widths of the request and result
  localparam int DN_W = 22;
  localparam int YR_W = 14;
  localparam int MO_W = 4;
  localparam int DY_W = 5;
  localparam int ST_W = 3;

  // Default last supported year
  localparam int MAX_YEAR_DEF = 9999;

  // Function codes
  localparam logic [1:0] FN_DN2DATE = 2'd0;
  localparam logic [1:0] FN_DATE2DN = 2'd1;
  localparam logic [1:0] FN_NTHWDAY = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_MONTH = 3'd2,
    ST_DAY   = 3'd3,
    ST_NTH   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [DN_W-1:0] day_number;
    logic [YR_W-1:0] year;
    logic [MO_W-1:0] month;
    logic [DY_W-1:0] day;
    logic [2:0]      nth;
    logic [2:0]      weekday;
  } req_t;

  typedef struct packed {
    logic [DN_W-1:0] day_number_out;
    logic [YR_W-1:0] year_out;
    logic [MO_W-1:0] month_out;
    logic [DY_W-1:0] day_out;
    status_t         status;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PERIOD,
    S_MONTH,
    S_FINISH
  } state_t;

  // Period stages: 400, 100, 4 and 1 years
  function automatic logic [17:0] period_days(input logic [1:0] stg);
    logic [17:0] d;
    case (stg)
      2'd0:    d = 18'd146097;
      2'd1:    d = 18'd36524;
      2'd2:    d = 18'd1461;
      default: d = 18'd365;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] period_years(input logic [1:0] stg);
    logic [8:0] y;
    case (stg)
      2'd0:    y = 9'd400;
      2'd1:    y = 9'd100;
      2'd2:    y = 9'd4;
      default: y = 9'd1;
    endcase
    return y;
  endfunction

  // Days of each period modulo 7
  function automatic logic [2:0] period_mod7(input logic [1:0] stg);
    logic [2:0] r;
    case (stg)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd5;
      2'd2:    r = 3'd5;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
      4'd2:                                       l = leap ? 5'd29 : 5'd28;
      default:                                    l = 5'd0;
    endcase
    return l;
  endfunction

  // (a + b) mod 7 for a in 0..6, b in 0..7
  function automatic logic [2:0] mod7_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

endpackage

/* rtl/core/day_number_date_converter_unit.sv */
// Top level of the proleptic Gregorian day-number / date converter.
// Depends on dndc_pkg.
`timescale 1ns / 1ps

// Converts day numbers (day 1 = 0001-01-01) to dates, dates to day numbers,
// and finds the nth weekday of a month (weekday 0 = Sunday). One request is
// worked at a time; req_ready is high only while the unit is idle. A single
// compare/subtract/add unit steps through 400-, 100-, 4- and 1-year periods,
// one period per cycle, then through the months, one per cycle. A request
// that fails the up-front range checks goes straight to the result stage.
// The result register holds a finished result until it is taken, while the
// unit already accepts the next request.
module day_number_date_converter_unit #(
  parameter int MAX_YEAR = dndc_pkg::MAX_YEAR_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dndc_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output dndc_pkg::res_t res
);
  import dndc_pkg::*;

  // Last valid day number and internal datapath width
  localparam int DN_MAX = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam int DN_MAX_W = $clog2(DN_MAX + 1);
  localparam int DW = (DN_MAX_W > DN_W) ? DN_MAX_W : DN_W;

  state_t          state, state_next;
  req_t            cur;
  status_t         st;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   acc;
  logic [1:0]      stg;
  logic [3:0]      mon;
  logic [1:0]      q100;
  logic [4:0]      q4;
  logic [1:0]      q1;
  logic [2:0]      wd7;

  logic            load_req;
  logic            load_res;
  status_t         early_st;
  logic            is_dn;
  logic            leap;
  logic [4:0]      mlen;
  logic [DW-1:0]   sub_op;
  logic [DW-1:0]   add_op;
  logic [2:0]      add7;
  logic [DW-1:0]   rem_diff;
  logic [DW-1:0]   acc_sum;
  logic [2:0]      wd7_sum;
  logic            rem_ge;
  logic            cnt_full;
  logic            per_take;
  logic            mon_go;
  logic [2:0]      s7;
  logic [2:0]      diff7;
  logic [5:0]      dd;
  logic [DW-1:0]   fin_sum;
  status_t         fin_st;
  res_t            res_next;

  // Up-front range checks on the incoming request
  always_comb begin
    early_st = ST_OK;
    case (req.func)
      FN_DN2DATE: begin
        if (req.day_number == '0 || DW'(req.day_number) > DW'(DN_MAX)) begin
          early_st = ST_RANGE;
        end
      end
      FN_DATE2DN: begin
        if (req.year == '0 || 32'(req.year) > 32'(MAX_YEAR)) begin
          early_st = ST_RANGE;
        end else if (req.month == '0 || req.month > 4'd12) begin
          early_st = ST_MONTH;
        end
      end
      FN_NTHWDAY: begin
        if (req.nth == '0 || req.nth > 3'd5 || req.weekday > 3'd6) begin
          early_st = ST_NTH;
        end else if (req.year == '0 || 32'(req.year) > 32'(MAX_YEAR)) begin
          early_st = ST_RANGE;
        end else if (req.month == '0 || req.month > 4'd12) begin
          early_st = ST_MONTH;
        end
      end
      default: early_st = ST_RANGE;
    endcase
  end

  // Leap flag from the period counts of the elapsed years
  assign is_dn = (cur.func == FN_DN2DATE);
  assign leap  = (q1 == 2'd3) && (q4 != 5'd24 || q100 == 2'd3);
  assign mlen  = month_len(mon, leap);

  // Shared step unit: operand select, compare/subtract, add, mod-7 add
  always_comb begin
    if (state == S_MONTH) begin
      sub_op = DW'(mlen);
      add_op = DW'(mlen);
      add7   = 3'(mlen - 5'd28);
    end else begin
      sub_op = is_dn ? DW'(period_days(stg)) : DW'(period_years(stg));
      add_op = is_dn ? DW'(period_years(stg)) : DW'(period_days(stg));
      add7   = period_mod7(stg);
    end
  end

  assign rem_ge   = (rem >= sub_op);
  assign rem_diff = rem - sub_op;
  assign acc_sum  = acc + add_op;
  assign wd7_sum  = mod7_add(wd7, add7);

  // Stage and month step decisions
  assign cnt_full = (stg == 2'd1 && q100 == 2'd3) || (stg == 2'd3 && q1 == 2'd3);
  assign per_take = rem_ge && !cnt_full;
  assign mon_go   = is_dn ? (mon < 4'd12 && rem_ge) : (mon < cur.month);

  // Weekday placement for the nth-weekday request
  assign s7    = mod7_add(wd7, 3'd1);
  assign diff7 = mod7_add(cur.weekday, 3'd7 - s7);
  assign dd    = 6'd1 + 6'(diff7) + 6'(cur.nth - 3'd1) * 6'd7;

  // Result assembly
  always_comb begin
    fin_sum  = acc + ((cur.func == FN_NTHWDAY) ? DW'(dd) : DW'(cur.day));
    fin_st   = st;
    if (st == ST_OK) begin
      if (cur.func == FN_DATE2DN && (cur.day == '0 || cur.day > mlen)) begin
        fin_st = ST_DAY;
      end else if (cur.func == FN_NTHWDAY && dd > {1'b0, mlen}) begin
        fin_st = ST_DAY;
      end
    end
    res_next = '0;
    res_next.status = fin_st;
    if (fin_st == ST_OK) begin
      if (is_dn) begin
        res_next.day_number_out = cur.day_number;
        res_next.year_out       = acc[YR_W-1:0] + YR_W'(1);
        res_next.month_out      = mon;
        res_next.day_out        = rem[DY_W-1:0] + DY_W'(1);
      end else begin
        res_next.day_number_out = fin_sum[DN_W-1:0];
        res_next.year_out       = cur.year;
        res_next.month_out      = cur.month;
        res_next.day_out        = (cur.func == FN_NTHWDAY) ? dd[DY_W-1:0] : cur.day;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (early_st != ST_OK) ? S_FINISH : S_PERIOD;
        end
      end
      S_PERIOD: begin
        if (!per_take && stg == 2'd3) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if (!mon_go) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_res) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and load strobes
  always_comb begin
    req_ready = (state == S_IDLE);
    load_req  = req_ready && req_valid;
    load_res  = (state == S_FINISH) && (!res_valid || res_ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_req) begin
      cur  <= req;
      st   <= early_st;
      rem  <= (req.func == FN_DN2DATE) ? DW'(req.day_number) - DW'(1)
                                       : DW'(req.year) - DW'(1);
      acc  <= '0;
      stg  <= 2'd0;
      mon  <= 4'd1;
      q100 <= 2'd0;
      q4   <= 5'd0;
      q1   <= 2'd0;
      wd7  <= 3'd0;
    end else if (state == S_PERIOD) begin
      if (per_take) begin
        rem <= rem_diff;
        acc <= acc_sum;
        wd7 <= wd7_sum;
        case (stg)
          2'd1:    q100 <= q100 + 2'd1;
          2'd2:    q4   <= q4 + 5'd1;
          2'd3:    q1   <= q1 + 2'd1;
          default: ;
        endcase
      end else if (stg != 2'd3) begin
        stg <= stg + 2'd1;
      end
    end else if (state == S_MONTH && mon_go) begin
      mon <= mon + 4'd1;
      if (is_dn) begin
        rem <= rem_diff;
      end else begin
        acc <= acc_sum;
        wd7 <= wd7_sum;
      end
    end
    if (load_res) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  // Month walk never leaves 1..12
  a_mon_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MONTH |-> (mon >= 4'd1 && mon <= 4'd12))
    else $error("month counter out of range");

  // At most 24 four-year periods fit in a century
  a_q4_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PERIOD || state == S_MONTH) |-> q4 <= 5'd24)
    else $error("four-year count overflow");

  // Errored results carry all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |->
      (res.day_number_out == '0 && res.year_out == '0 &&
       res.month_out == '0 && res.day_out == '0))
    else $error("nonzero fields on error result");

  // Good results carry a real date
  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OK) |->
      (res.month_out != '0 && res.day_out != '0 && res.day_number_out != '0))
    else $error("invalid date on good result");

  // A request failing the up-front checks goes straight to the result stage
  a_early_err: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && early_st != ST_OK) |=> state == S_FINISH)
    else $error("errored request entered stepping");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for day_number_date_converter_unit: random and directed
// calendar requests are checked against a built-in calendar predictor.
// Depends on dndc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;

  import dndc_pkg::*;

  localparam int MAX_YEAR = MAX_YEAR_DEF;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int N_RANDOM = 1750;
  localparam int MAX_SHOWN = 10;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  req_t conversion_reqs_q[$];
  res_t calendar_answers_q[$];
  int unsigned reqs_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned error_cnt = 0;

  day_number_date_converter_unit #(
    .MAX_YEAR(MAX_YEAR)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------------

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Day number of Dec 31 of year y
  function automatic int unsigned year_end_day(int unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int unsigned date_to_ordinal(int unsigned y, int unsigned m,
                                                  int unsigned d);
    int unsigned n;
    n = year_end_day(y - 1);
    for (int unsigned k = 1; k < m; k++) begin
      n += month_days(y, k);
    end
    return n + d;
  endfunction

  // Expected answer for one request
  function automatic res_t calendar_convert(req_t rq);
    res_t ans;
    int unsigned dn, y, m, d, nth, wd, r, q, yy, mm, first, dd;
    ans = '0;
    ans.status = ST_OK;
    dn = 32'(rq.day_number);
    y = 32'(rq.year);
    m = 32'(rq.month);
    d = 32'(rq.day);
    nth = 32'(rq.nth);
    wd = 32'(rq.weekday);
    case (rq.func)
      FN_DN2DATE: begin
        if (dn == 0 || dn > year_end_day(MAX_YEAR)) begin
          ans.status = ST_RANGE;
        end else begin
          // peel off 400-, 100-, 4- and 1-year periods
          r = dn - 1;
          q = r / 146097;
          r = r % 146097;
          yy = q * 400;
          q = r / 36524;
          if (q > 3) q = 3;
          r -= q * 36524;
          yy += q * 100;
          q = r / 1461;
          r = r % 1461;
          yy += q * 4;
          q = r / 365;
          if (q > 3) q = 3;
          r -= q * 365;
          yy += q + 1;
          mm = 1;
          while (mm < 12 && r >= month_days(yy, mm)) begin
            r -= month_days(yy, mm);
            mm++;
          end
          ans.day_number_out = DN_W'(dn);
          ans.year_out = YR_W'(yy);
          ans.month_out = MO_W'(mm);
          ans.day_out = DY_W'(r + 1);
        end
      end
      FN_DATE2DN: begin
        if (y == 0 || y > MAX_YEAR) begin
          ans.status = ST_RANGE;
        end else if (m == 0 || m > 12) begin
          ans.status = ST_MONTH;
        end else if (d == 0 || d > month_days(y, m)) begin
          ans.status = ST_DAY;
        end else begin
          ans.day_number_out = DN_W'(date_to_ordinal(y, m, d));
          ans.year_out = YR_W'(y);
          ans.month_out = MO_W'(m);
          ans.day_out = DY_W'(d);
        end
      end
      FN_NTHWDAY: begin
        // occurrence and weekday are checked ahead of year and month
        if (nth == 0 || nth > 5 || wd > 6) begin
          ans.status = ST_NTH;
        end else if (y == 0 || y > MAX_YEAR) begin
          ans.status = ST_RANGE;
        end else if (m == 0 || m > 12) begin
          ans.status = ST_MONTH;
        end else begin
          first = date_to_ordinal(y, m, 1);
          dd = 1 + ((wd + 7 - first % 7) % 7) + 7 * (nth - 1);
          if (dd > month_days(y, m)) begin
            ans.status = ST_DAY;
          end else begin
            ans.day_number_out = DN_W'(first + dd - 1);
            ans.year_out = YR_W'(y);
            ans.month_out = MO_W'(m);
            ans.day_out = DY_W'(dd);
          end
        end
      end
      default: begin
        ans.status = ST_RANGE;
      end
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(logic [1:0] fn, int unsigned dn, int unsigned y,
                                    int unsigned m, int unsigned d, int unsigned nth,
                                    int unsigned wd);
    req_t rq;
    rq.func = fn;
    rq.day_number = DN_W'(dn);
    rq.year = YR_W'(y);
    rq.month = MO_W'(m);
    rq.day = DY_W'(d);
    rq.nth = 3'(nth);
    rq.weekday = 3'(wd);
    return rq;
  endfunction

  // Mostly well-formed requests with random content, the rest raw noise
  function automatic req_t random_request();
    req_t rq;
    int unsigned pick, y, m;
    rq = make_req(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) begin
      y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 5)
                                      : $urandom_range(MAX_YEAR - 4, MAX_YEAR);
    end else begin
      y = $urandom_range(1, MAX_YEAR);
    end
    m = $urandom_range(1, 12);
    if (pick < 30) begin
      rq.func = FN_DN2DATE;
      if (pick < 26) begin
        rq.day_number = DN_W'($urandom_range(1, year_end_day(MAX_YEAR)));
      end
    end else if (pick < 60) begin
      rq.func = FN_DATE2DN;
      if (pick < 54) begin
        rq.year = YR_W'(y);
        rq.month = MO_W'(m);
        rq.day = DY_W'($urandom_range(1, month_days(y, m)));
      end
    end else if (pick < 90) begin
      rq.func = FN_NTHWDAY;
      if (pick < 84) begin
        rq.year = YR_W'(y);
        rq.month = MO_W'(m);
        rq.nth = 3'($urandom_range(1, 5));
        rq.weekday = 3'($urandom_range(0, 6));
      end
    end
    return rq;
  endfunction

  task automatic flag_error(string msg);
    if (error_cnt < MAX_SHOWN) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  int unsigned tx_gap = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (req_valid && req_ready) begin
        calendar_answers_q.push_back(calendar_convert(req));
        reqs_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          req_valid <= 1'b0;
        end else if (conversion_reqs_q.size() != 0) begin
          req <= conversion_reqs_q.pop_front();
          req_valid <= 1'b1;
          // occasional switch between back-to-back and gapped traffic
          if ($urandom_range(0, 47) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and checker
  // ---------------------------------------------------------------------------
  int unsigned rx_stall = 0;
  int unsigned rx_hold = 0;
  bit rx_burst = 1'b0;

  always @(posedge clk) begin
    res_t want;
    logic ready_nxt;
    if (rst) begin
      res_ready <= 1'b0;
      rx_stall = 0;
      rx_hold = 0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (calendar_answers_q.size() == 0) begin
          flag_error($sformatf("unexpected result dn=%0d y=%0d m=%0d d=%0d st=%0d",
                               res.day_number_out, res.year_out, res.month_out,
                               res.day_out, res.status));
        end else begin
          want = calendar_answers_q.pop_front();
          if (res.day_number_out !== want.day_number_out ||
              res.year_out !== want.year_out || res.month_out !== want.month_out ||
              res.day_out !== want.day_out || res.status !== want.status) begin
            flag_error($sformatf(
                "mismatch: expected dn=%0d y=%0d m=%0d d=%0d st=%0d, got dn=%0d y=%0d m=%0d d=%0d st=%0d",
                want.day_number_out, want.year_out, want.month_out, want.day_out,
                want.status, res.day_number_out, res.year_out, res.month_out,
                res.day_out, res.status));
          end
        end
        // one long back-pressure stretch so the unit fills and stalls requests
        if (results_seen == HOLD_AT_RESULT) rx_hold = HOLD_CYCLES;
        if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        ready_nxt = 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      res_ready <= ready_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned total;
    int unsigned waited;

    // day number extremes and out-of-range values
    conversion_reqs_q.push_back(make_req(FN_DN2DATE, 1, 0, 0, 0, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DN2DATE, 0, 0, 0, 0, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DN2DATE, year_end_day(MAX_YEAR), 0, 0, 0, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DN2DATE, year_end_day(MAX_YEAR) + 1,
                                         0, 0, 0, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DN2DATE, 22'h3FFFFF, 16383, 15, 31, 7, 7));
    conversion_reqs_q.push_back(make_req(FN_DN2DATE, date_to_ordinal(2000, 2, 29),
                                         0, 0, 0, 0, 0));
    // date to day number: extremes, leap rules, check order
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 1, 1, 1, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, MAX_YEAR, 12, 31, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 0, 1, 1, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, MAX_YEAR + 1, 1, 1, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 16383, 0, 0, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 2000, 0, 0, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 2000, 15, 1, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 2000, 2, 29, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 1900, 2, 29, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 2001, 4, 31, 0, 0));
    conversion_reqs_q.push_back(make_req(FN_DATE2DN, 0, 2001, 4, 0, 0, 0));
    // nth weekday: bad occurrence or weekday ahead of the year check
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 0, 0, 0, 0, 3));
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 2020, 5, 0, 6, 3));
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 0, 13, 0, 2, 7));
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 0, 3, 0, 1, 1));
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 2020, 13, 0, 1, 1));
    // missing fifth Sunday in a 28-day February, present fifth Monday in a leap one
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 2015, 2, 0, 5, 0));
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, 2016, 2, 0, 5, 1));
    conversion_reqs_q.push_back(make_req(FN_NTHWDAY, 0, MAX_YEAR, 12, 0, 5, 6));
    conversion_reqs_q.push_back(make_req(FN_UNUSED, 1000, 2000, 6, 15, 2, 3));

    repeat (N_RANDOM) conversion_reqs_q.push_back(random_request());
    total = conversion_reqs_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (reqs_accepted < total) @(posedge clk);
    waited = 0;
    while (calendar_answers_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (calendar_answers_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", calendar_answers_q.size()));
    end

    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
